### rtl/ccp_pkg.sv
// shared types, constants, a magnitude helper and a saturating add for the cubic segment closest point block
package ccp_pkg;

	localparam int MAX_SAMPLES_DEF = 256;
	localparam int COORD_BITS_DEF = 32;

	localparam int T_W = 20;
	localparam int SP_W = 17;
	localparam int MS_W = 9;
	localparam int NL_W = 4;
	localparam int TOL_W = 16;
	localparam int TAG_W = 16;
	localparam int DIST_W = 63;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam int NUM_W = 80;
	localparam int DEN_W = 64;
	localparam int CNT_W = 7;
	localparam int STEP_W = 41;

	localparam logic [SP_W-1:0] SPACING_RST = 17'd3277;
	localparam logic [MS_W-1:0] MIN_SAMPLES_RST = 9'd5;
	localparam logic [NL_W-1:0] NEWTON_LIMIT_RST = 4'd8;
	localparam logic [TOL_W-1:0] STEP_TOL_RST = 16'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEWTON_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_TOL = 2'd3;

	localparam logic [63:0] GP_EPS = 64'd4295;
	localparam logic [STEP_W-1:0] STEP_CAP = 41'h100_0000_0000;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] c;
		logic sh16;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] value;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [CNT_W-1:0] count;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [63:0] magn64(input logic signed [63:0] v);
		logic [63:0] u;
		u = v;
		return u[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
		return s[63:0];
	endfunction

endpackage

### rtl/ccp_mul.sv
// iterative saturating 64x64 multiply-shift-add on one 32x32 multiplier
module ccp_mul
	import ccp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input mul_req_t req,
	output mul_rsp_t rsp
);

	localparam logic [2:0] PH_LAST_PP = 3'd3;
	localparam logic [2:0] PH_LAST_ACC = 3'd4;
	localparam logic [2:0] PH_SAT = 3'd5;
	localparam logic [2:0] PH_ADD = 3'd6;

	logic busy_q;
	logic [2:0] phase_q;
	logic done_q;

	logic [63:0] ua_q, ub_q;
	logic neg_q, sh_q;
	logic signed [63:0] c_q;
	logic [63:0] pp_q;
	logic [1:0] pp_sel_q;
	logic [127:0] acc_q;
	logic signed [63:0] m_q, res_q;

	logic [31:0] opa, opb;
	logic [127:0] pp_shifted, shifted;
	logic [63:0] lim, mag;

	always_comb begin
		case (phase_q[1:0])
			2'd0: begin
				opa = ua_q[31:0];
				opb = ub_q[31:0];
			end
			2'd1: begin
				opa = ua_q[31:0];
				opb = ub_q[63:32];
			end
			2'd2: begin
				opa = ua_q[63:32];
				opb = ub_q[31:0];
			end
			default: begin
				opa = ua_q[63:32];
				opb = ub_q[63:32];
			end
		endcase
	end

	always_comb begin
		case (pp_sel_q) inside
			2'd0: pp_shifted = {64'd0, pp_q};
			2'd1, 2'd2: pp_shifted = {32'd0, pp_q, 32'd0};
			default: pp_shifted = {pp_q, 64'd0};
		endcase
	end

	always_comb begin
		shifted = sh_q ? (acc_q >> 16) : acc_q;
		lim = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (shifted[127:64] != 64'd0 || shifted[63:0] > lim)
			mag = lim;
		else
			mag = shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && phase_q == PH_ADD;
			if (req.start) begin
				busy_q <= 1'b1;
				phase_q <= 3'd0;
			end else if (busy_q) begin
				phase_q <= phase_q + 3'd1;
				if (phase_q == PH_ADD)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q <= magn64(req.a);
			ub_q <= magn64(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			sh_q <= req.sh16;
			c_q <= req.c;
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (phase_q <= PH_LAST_PP) begin
				pp_q <= opa * opb;
				pp_sel_q <= phase_q[1:0];
			end
			if (phase_q >= 3'd1 && phase_q <= PH_LAST_ACC)
				acc_q <= acc_q + pp_shifted;
			if (phase_q == PH_SAT)
				m_q <= neg_q ? signed'(~mag + 64'd1) : signed'(mag);
			if (phase_q == PH_ADD)
				res_q <= sat_add64(m_q, c_q);
		end
	end

	assign rsp.done = done_q;
	assign rsp.value = res_q;

endmodule

### rtl/ccp_div.sv
// restoring divider, one quotient bit per cycle over the top count bits of the numerator
module ccp_div
	import ccp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] num_q;

	logic [DEN_W:0] rem_sh, rem_sub;
	logic ge;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && cnt_q == CNT_W'(1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = num_q;

endmodule

### rtl/cubic_segment_closest_point.sv
// Nearest point on a planar cubic segment: coarse scan then Newton refinement, one shared
// multiplier and one divider run by a microcoded sequencer. One item at a time; every
// item runs n+1 coarse samples (each of 8 multiplies, 2 adds and one sample time division)
// plus up to newton_limit Newton steps (each of 20 multiplies and at most one 80-bit step
// division) plus a final evaluation.
// The result waits in an output register while the next item is taken in.
module cubic_segment_closest_point
	import ccp_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic signed [COORD_BITS-1:0] coeff_x0,
	input logic signed [COORD_BITS-1:0] coeff_x1,
	input logic signed [COORD_BITS-1:0] coeff_x2,
	input logic signed [COORD_BITS-1:0] coeff_x3,
	input logic signed [COORD_BITS-1:0] coeff_y0,
	input logic signed [COORD_BITS-1:0] coeff_y1,
	input logic signed [COORD_BITS-1:0] coeff_y2,
	input logic signed [COORD_BITS-1:0] coeff_y3,
	input logic [T_W-1:0] duration,
	input logic signed [COORD_BITS-1:0] query_x,
	input logic signed [COORD_BITS-1:0] query_y,
	input logic [TAG_W-1:0] segment_index,
	output logic result_valid,
	input logic result_stall,
	output logic [TAG_W-1:0] segment_tag,
	output logic [T_W-1:0] param_t,
	output logic signed [COORD_BITS-1:0] nearest_x,
	output logic signed [COORD_BITS-1:0] nearest_y,
	output logic [DIST_W-1:0] dist_sq,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = NW + T_W;
	localparam logic [T_W:0] MAXN = (T_W + 1)'(MAX_SAMPLES);
	localparam logic signed [63:0] C_MAX = signed'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic signed [63:0] C_MIN = -C_MAX - 64'sd1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NDIV = 4'd1;
	localparam logic [3:0] S_TDIV = 4'd2;
	localparam logic [3:0] S_RUN = 4'd3;
	localparam logic [3:0] S_CMP = 4'd4;
	localparam logic [3:0] S_NTOP = 4'd5;
	localparam logic [3:0] S_NCHK = 4'd6;
	localparam logic [3:0] S_SDIV = 4'd7;
	localparam logic [3:0] S_TUPD = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	localparam logic [1:0] M_SCAN = 2'd0;
	localparam logic [1:0] M_NEWT = 2'd1;
	localparam logic [1:0] M_FIN = 2'd2;

	localparam logic [4:0] PC_EVAL_END = 5'd9;
	localparam logic [4:0] PC_NEWT_END = 5'd22;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_MUL = 1'b1;

	localparam logic [4:0] OP_ZERO = 5'd0;
	localparam logic [4:0] OP_T = 5'd1;
	localparam logic [4:0] OP_CX0 = 5'd2;
	localparam logic [4:0] OP_CX1 = 5'd3;
	localparam logic [4:0] OP_CX2 = 5'd4;
	localparam logic [4:0] OP_CX3 = 5'd5;
	localparam logic [4:0] OP_CY0 = 5'd6;
	localparam logic [4:0] OP_CY1 = 5'd7;
	localparam logic [4:0] OP_CY2 = 5'd8;
	localparam logic [4:0] OP_CY3 = 5'd9;
	localparam logic [4:0] OP_CX2D = 5'd10;
	localparam logic [4:0] OP_CY2D = 5'd11;
	localparam logic [4:0] OP_CX3T = 5'd12;
	localparam logic [4:0] OP_CY3T = 5'd13;
	localparam logic [4:0] OP_CX3S = 5'd14;
	localparam logic [4:0] OP_CY3S = 5'd15;
	localparam logic [4:0] OP_NQX = 5'd16;
	localparam logic [4:0] OP_NQY = 5'd17;
	localparam logic [4:0] OP_ACC = 5'd18;
	localparam logic [4:0] OP_PX = 5'd19;
	localparam logic [4:0] OP_PY = 5'd20;
	localparam logic [4:0] OP_EX = 5'd21;
	localparam logic [4:0] OP_EY = 5'd22;
	localparam logic [4:0] OP_D1X = 5'd23;
	localparam logic [4:0] OP_D1Y = 5'd24;
	localparam logic [4:0] OP_D2X = 5'd25;
	localparam logic [4:0] OP_D2Y = 5'd26;
	localparam logic [4:0] OP_TMP = 5'd27;
	localparam logic [4:0] OP_TMP2 = 5'd28;
	localparam logic [4:0] OP_G = 5'd29;
	localparam logic [4:0] OP_GP = 5'd30;
	localparam logic [4:0] OP_DIST = 5'd31;

	typedef struct packed {
		logic kind;
		logic [4:0] a;
		logic [4:0] b;
		logic [4:0] c;
		logic sh;
		logic [4:0] dst;
	} uop_t;

	function automatic uop_t ucode(input logic [4:0] pc);
		uop_t u;
		case (pc)
			5'd0: u = '{KIND_MUL, OP_CX3, OP_T, OP_CX2, 1'b1, OP_ACC};
			5'd1: u = '{KIND_MUL, OP_ACC, OP_T, OP_CX1, 1'b1, OP_ACC};
			5'd2: u = '{KIND_MUL, OP_ACC, OP_T, OP_CX0, 1'b1, OP_PX};
			5'd3: u = '{KIND_MUL, OP_CY3, OP_T, OP_CY2, 1'b1, OP_ACC};
			5'd4: u = '{KIND_MUL, OP_ACC, OP_T, OP_CY1, 1'b1, OP_ACC};
			5'd5: u = '{KIND_MUL, OP_ACC, OP_T, OP_CY0, 1'b1, OP_PY};
			5'd6: u = '{KIND_ADD, OP_PX, OP_ZERO, OP_NQX, 1'b0, OP_EX};
			5'd7: u = '{KIND_ADD, OP_PY, OP_ZERO, OP_NQY, 1'b0, OP_EY};
			5'd8: u = '{KIND_MUL, OP_EX, OP_EX, OP_ZERO, 1'b0, OP_TMP};
			5'd9: u = '{KIND_MUL, OP_EY, OP_EY, OP_TMP, 1'b0, OP_DIST};
			5'd10: u = '{KIND_MUL, OP_CX3T, OP_T, OP_CX2D, 1'b1, OP_ACC};
			5'd11: u = '{KIND_MUL, OP_ACC, OP_T, OP_CX1, 1'b1, OP_D1X};
			5'd12: u = '{KIND_MUL, OP_CY3T, OP_T, OP_CY2D, 1'b1, OP_ACC};
			5'd13: u = '{KIND_MUL, OP_ACC, OP_T, OP_CY1, 1'b1, OP_D1Y};
			5'd14: u = '{KIND_MUL, OP_CX3S, OP_T, OP_CX2D, 1'b1, OP_D2X};
			5'd15: u = '{KIND_MUL, OP_CY3S, OP_T, OP_CY2D, 1'b1, OP_D2Y};
			5'd16: u = '{KIND_MUL, OP_EX, OP_D1X, OP_ZERO, 1'b0, OP_TMP};
			5'd17: u = '{KIND_MUL, OP_EY, OP_D1Y, OP_TMP, 1'b0, OP_G};
			5'd18: u = '{KIND_MUL, OP_D1X, OP_D1X, OP_ZERO, 1'b0, OP_TMP};
			5'd19: u = '{KIND_MUL, OP_D1Y, OP_D1Y, OP_TMP, 1'b0, OP_TMP};
			5'd20: u = '{KIND_MUL, OP_EX, OP_D2X, OP_ZERO, 1'b0, OP_TMP2};
			5'd21: u = '{KIND_MUL, OP_EY, OP_D2Y, OP_TMP2, 1'b0, OP_TMP2};
			5'd22: u = '{KIND_ADD, OP_TMP, OP_ZERO, OP_TMP2, 1'b0, OP_GP};
			default: u = '{KIND_ADD, OP_ZERO, OP_ZERO, OP_ZERO, 1'b0, OP_ZERO};
		endcase
		return u;
	endfunction

	// config registers
	logic [SP_W-1:0] sp_q;
	logic [MS_W-1:0] ms_q;
	logic [NL_W-1:0] nl_q;
	logic [TOL_W-1:0] tol_q;

	// control
	logic [3:0] state_q;
	logic [1:0] mode_q;
	logic [4:0] pc_q;
	logic wait_q;
	logic [NW-1:0] n_q, i_q;
	logic [NL_W-1:0] it_q;
	logic res_valid_q;

	// item and work registers
	logic signed [COORD_BITS-1:0] cx_q [4];
	logic signed [COORD_BITS-1:0] cy_q [4];
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic [T_W-1:0] dur_q, t_q, tc_q;
	logic [TAG_W-1:0] seg_q;
	logic [AW-1:0] num_q;
	logic signed [63:0] acc_q, px_q, py_q, ex_q, ey_q, d1x_q, d1y_q, d2x_q, d2y_q;
	logic signed [63:0] tmp_q, tmp2_q, g_q, gp_q, dist_q, best_q;
	logic [STEP_W-1:0] dmag_q;
	logic dneg_q;

	// output register
	logic [TAG_W-1:0] seg_tag_q;
	logic [T_W-1:0] param_t_q;
	logic signed [COORD_BITS-1:0] near_x_q, near_y_q;
	logic [DIST_W-1:0] dist_sq_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	uop_t uop;
	logic signed [63:0] opa, opb, opc, wr_val;
	logic wr_en;
	logic [4:0] pc_end;
	logic item_acc, out_free;
	logic [SP_W-1:0] sp_eff;
	logic [T_W:0] n_raw, n_clamp;
	logic upd;
	logic [63:0] ug, ugp;
	logic step_cap, gp_flat;
	logic signed [T_W+22:0] t_ext, m_ext, tn;
	logic [T_W-1:0] t_new;
	logic step_small;

	function automatic logic signed [63:0] pick(input logic [4:0] sel);
		logic signed [63:0] cx3e, cy3e;
		cx3e = 64'(cx_q[3]);
		cy3e = 64'(cy_q[3]);
		case (sel)
			OP_T: return signed'({{(64 - T_W){1'b0}}, t_q});
			OP_CX0: return 64'(cx_q[0]);
			OP_CX1: return 64'(cx_q[1]);
			OP_CX2: return 64'(cx_q[2]);
			OP_CX3: return cx3e;
			OP_CY0: return 64'(cy_q[0]);
			OP_CY1: return 64'(cy_q[1]);
			OP_CY2: return 64'(cy_q[2]);
			OP_CY3: return cy3e;
			OP_CX2D: return 64'(cx_q[2]) <<< 1;
			OP_CY2D: return 64'(cy_q[2]) <<< 1;
			OP_CX3T: return cx3e + (cx3e <<< 1);
			OP_CY3T: return cy3e + (cy3e <<< 1);
			OP_CX3S: return (cx3e + (cx3e <<< 1)) <<< 1;
			OP_CY3S: return (cy3e + (cy3e <<< 1)) <<< 1;
			OP_NQX: return -64'(qx_q);
			OP_NQY: return -64'(qy_q);
			OP_ACC: return acc_q;
			OP_PX: return px_q;
			OP_PY: return py_q;
			OP_EX: return ex_q;
			OP_EY: return ey_q;
			OP_D1X: return d1x_q;
			OP_D1Y: return d1y_q;
			OP_D2X: return d2x_q;
			OP_D2Y: return d2y_q;
			OP_TMP: return tmp_q;
			OP_TMP2: return tmp2_q;
			default: return 64'sd0;
		endcase
	endfunction

	ccp_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.rsp(mul_rsp)
	);

	ccp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign item_stall = state_q != S_IDLE;
	assign item_acc = item_valid && !item_stall;
	assign cfg_ready = 1'b1;
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		uop = ucode(pc_q);
		opa = pick(uop.a);
		opb = pick(uop.b);
		opc = pick(uop.c);
		pc_end = (mode_q == M_NEWT) ? PC_NEWT_END : PC_EVAL_END;
		wr_en = state_q == S_RUN && (uop.kind == KIND_ADD || (wait_q && mul_rsp.done));
		wr_val = (uop.kind == KIND_ADD) ? sat_add64(opa, opc) : mul_rsp.value;

		mul_req.start = state_q == S_RUN && uop.kind == KIND_MUL && !wait_q;
		mul_req.a = opa;
		mul_req.b = opb;
		mul_req.c = opc;
		mul_req.sh16 = uop.sh;
	end

	always_comb begin
		sp_eff = (sp_q == '0) ? SP_W'(1) : sp_q;
		ug = magn64(g_q);
		ugp = magn64(gp_q);
		div_req.start = !wait_q && (state_q == S_NDIV || state_q == S_TDIV
			|| state_q == S_SDIV);
		case (state_q)
			S_NDIV: begin
				div_req.num = {dur_q, {(NUM_W - T_W){1'b0}}};
				div_req.den = {{(DEN_W - SP_W){1'b0}}, sp_eff};
				div_req.count = CNT_W'(T_W);
			end
			S_TDIV: begin
				div_req.num = {num_q, {(NUM_W - AW){1'b0}}};
				div_req.den = {{(DEN_W - NW){1'b0}}, n_q};
				div_req.count = CNT_W'(AW);
			end
			default: begin
				div_req.num = {ug, 16'd0};
				div_req.den = ugp;
				div_req.count = CNT_W'(NUM_W);
			end
		endcase
	end

	always_comb begin
		n_raw = div_rsp.quo[T_W:0];
		if (n_raw < {{(T_W + 1 - MS_W){1'b0}}, ms_q})
			n_raw = {{(T_W + 1 - MS_W){1'b0}}, ms_q};
		n_clamp = n_raw;
		if (n_raw == '0)
			n_clamp = (T_W + 1)'(1);
		if (n_raw > MAXN)
			n_clamp = MAXN;

		upd = i_q == '0 || dist_q < best_q;
		step_cap = (ug >> 24) >= ugp;
		gp_flat = ugp < GP_EPS;

		t_ext = signed'({{23{1'b0}}, t_q});
		m_ext = signed'({{(T_W + 23 - STEP_W){1'b0}}, dmag_q});
		tn = dneg_q ? t_ext + m_ext : t_ext - m_ext;
		if (tn < 0)
			t_new = '0;
		else if (tn > signed'({{23{1'b0}}, dur_q}))
			t_new = dur_q;
		else
			t_new = tn[T_W-1:0];
		step_small = dmag_q < {{(STEP_W - TOL_W){1'b0}}, tol_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= SPACING_RST;
			ms_q <= MIN_SAMPLES_RST;
			nl_q <= NEWTON_LIMIT_RST;
			tol_q <= STEP_TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SPACING: sp_q <= cfg_data[SP_W-1:0];
				CFG_MIN_SAMPLES: ms_q <= cfg_data[MS_W-1:0];
				CFG_NEWTON_LIMIT: nl_q <= cfg_data[NL_W-1:0];
				CFG_STEP_TOL: tol_q <= cfg_data[TOL_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_SCAN;
			pc_q <= '0;
			wait_q <= 1'b0;
			n_q <= '0;
			i_q <= '0;
			it_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_acc)
						state_q <= S_NDIV;
				end
				S_NDIV: begin
					if (!wait_q)
						wait_q <= 1'b1;
					else if (div_rsp.done) begin
						wait_q <= 1'b0;
						n_q <= NW'(n_clamp);
						i_q <= '0;
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (!wait_q)
						wait_q <= 1'b1;
					else if (div_rsp.done) begin
						wait_q <= 1'b0;
						mode_q <= M_SCAN;
						pc_q <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (uop.kind == KIND_MUL && !wait_q)
						wait_q <= 1'b1;
					else if (wr_en)
						wait_q <= 1'b0;
					if (wr_en) begin
						if (pc_q == pc_end) begin
							pc_q <= '0;
							unique case (mode_q)
								M_SCAN: state_q <= S_CMP;
								M_NEWT: state_q <= S_NCHK;
								default: state_q <= S_OUT;
							endcase
						end else
							pc_q <= pc_q + 5'd1;
					end
				end
				S_CMP: begin
					if (i_q == n_q) begin
						it_q <= '0;
						state_q <= S_NTOP;
					end else begin
						i_q <= i_q + NW'(1);
						state_q <= S_TDIV;
					end
				end
				S_NTOP: begin
					mode_q <= (it_q == nl_q) ? M_FIN : M_NEWT;
					pc_q <= '0;
					state_q <= S_RUN;
				end
				S_NCHK: begin
					if (gp_flat) begin
						mode_q <= M_FIN;
						pc_q <= '0;
						state_q <= S_RUN;
					end else if (step_cap)
						state_q <= S_TUPD;
					else
						state_q <= S_SDIV;
				end
				S_SDIV: begin
					if (!wait_q)
						wait_q <= 1'b1;
					else if (div_rsp.done) begin
						wait_q <= 1'b0;
						state_q <= S_TUPD;
					end
				end
				S_TUPD: begin
					if (step_small) begin
						mode_q <= M_FIN;
						pc_q <= '0;
						state_q <= S_RUN;
					end else begin
						it_q <= it_q + NL_W'(1);
						state_q <= S_NTOP;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			cx_q[0] <= coeff_x0;
			cx_q[1] <= coeff_x1;
			cx_q[2] <= coeff_x2;
			cx_q[3] <= coeff_x3;
			cy_q[0] <= coeff_y0;
			cy_q[1] <= coeff_y1;
			cy_q[2] <= coeff_y2;
			cy_q[3] <= coeff_y3;
			qx_q <= query_x;
			qy_q <= query_y;
			dur_q <= duration;
			seg_q <= segment_index;
		end
		if (state_q == S_NDIV)
			num_q <= '0;
		if (state_q == S_TDIV && wait_q && div_rsp.done)
			t_q <= div_rsp.quo[T_W-1:0];
		if (state_q == S_CMP) begin
			if (upd) begin
				best_q <= dist_q;
				tc_q <= t_q;
			end
			if (i_q == n_q)
				t_q <= upd ? t_q : tc_q;
			else
				num_q <= num_q + AW'(dur_q);
		end
		if (state_q == S_NCHK) begin
			dneg_q <= g_q[63] ^ gp_q[63];
			dmag_q <= STEP_CAP;
		end
		if (state_q == S_SDIV && wait_q && div_rsp.done)
			dmag_q <= div_rsp.quo[STEP_W-1:0];
		if (state_q == S_TUPD)
			t_q <= t_new;
		if (wr_en) begin
			case (uop.dst)
				OP_ACC: acc_q <= wr_val;
				OP_PX: px_q <= wr_val;
				OP_PY: py_q <= wr_val;
				OP_EX: ex_q <= wr_val;
				OP_EY: ey_q <= wr_val;
				OP_D1X: d1x_q <= wr_val;
				OP_D1Y: d1y_q <= wr_val;
				OP_D2X: d2x_q <= wr_val;
				OP_D2Y: d2y_q <= wr_val;
				OP_TMP: tmp_q <= wr_val;
				OP_TMP2: tmp2_q <= wr_val;
				OP_G: g_q <= wr_val;
				OP_GP: gp_q <= wr_val;
				OP_DIST: dist_q <= wr_val;
				default: ;
			endcase
		end
		if (state_q == S_OUT && out_free) begin
			seg_tag_q <= seg_q;
			param_t_q <= t_q;
			if (px_q > C_MAX)
				near_x_q <= C_MAX[COORD_BITS-1:0];
			else if (px_q < C_MIN)
				near_x_q <= C_MIN[COORD_BITS-1:0];
			else
				near_x_q <= px_q[COORD_BITS-1:0];
			if (py_q > C_MAX)
				near_y_q <= C_MAX[COORD_BITS-1:0];
			else if (py_q < C_MIN)
				near_y_q <= C_MIN[COORD_BITS-1:0];
			else
				near_y_q <= py_q[COORD_BITS-1:0];
			dist_sq_q <= dist_q[DIST_W-1:0];
		end
	end

	assign result_valid = res_valid_q;
	assign segment_tag = seg_tag_q;
	assign param_t = param_t_q;
	assign nearest_x = near_x_q;
	assign nearest_y = near_y_q;
	assign dist_sq = dist_sq_q;

`ifndef SYNTHESIS
	a_t_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> t_q <= dur_q)
		else $error("curve parameter beyond duration");

	a_n_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TDIV |-> (n_q != '0 && n_q <= NW'(MAX_SAMPLES)))
		else $error("sample count out of range");

	a_i_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TDIV |-> i_q <= n_q)
		else $error("sample index past sample count");

	a_mul_latency: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |=> !mul_rsp.done)
		else $error("multiplier done right after start");

	a_newton_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && mode_q == M_NEWT) |-> it_q < nl_q)
		else $error("newton step past limit");
`endif

endmodule
